// ===== design/clock_writeback_cache_controller_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the write-back cache controller
// Concurrent checks sampled on clk and disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef CLOCK_WRITEBACK_CACHE_CONTROLLER_ASSERT_SVH
`define CLOCK_WRITEBACK_CACHE_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define CWBC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cwbc check failed");
// Next-cycle implication.
`define CWBC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cwbc check failed");
`else
`define CWBC_ASSERT_IMP(name, ante, cons)
`define CWBC_ASSERT_NXT(name, ante, cons)
`endif
`endif

// ===== design/cwbc_pkg.sv =====
// ---------------------------------------------------------------------------
// cwbc_pkg
// Shared codes, widths and controller/datapath interface types.
// ---------------------------------------------------------------------------
package cwbc_pkg;

  localparam int SECTOR_W    = 32;
  localparam int SLOT_W      = 6;
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = 7;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FLUSH = 2'd2
  } cwbc_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic req_load;
    logic look_start;
    logic look_step;
    logic hand_pass;
    logic victim_take;
    logic emit_hit;
    logic emit_miss;
    logic flush_start;
    logic idx_step;
    logic flush_capture;
    logic flush_finish;
  } cwbc_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] req_cmd;
    logic       match;
    logic       scan_end;
    logic       idx_end;
    logic       use_hand;
    logic       idx_dirty;
    logic       cnt_full;
    logic       pend_valid;
    logic       out_free;
  } cwbc_sts_t;

endpackage

// ===== design/cwbc_ctrl.sv =====
// ---------------------------------------------------------------------------
// cwbc_ctrl
// Sequencer for lookup, clock sweep, victim install and flush walk.
// ---------------------------------------------------------------------------
`include "clock_writeback_cache_controller_assert.svh"

module cwbc_ctrl
  import cwbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  cwbc_sts_t sts,
  output cwbc_ctl_t ctl
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_LOOK,
    S_HIT,
    S_SWEEP,
    S_VREAD,
    S_VEMIT,
    S_FSCAN,
    S_FCAPT,
    S_FLAST
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.req_load = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.req_cmd) inside
          CMD_READ, CMD_WRITE: begin
            ctl.look_start = 1'b1;
            state_next     = S_LOOK;
          end
          CMD_FLUSH: begin
            ctl.flush_start = 1'b1;
            state_next      = S_FSCAN;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_LOOK: begin
        if (sts.match) begin
          state_next = S_HIT;
        end else if (sts.scan_end) begin
          state_next = S_SWEEP;
        end else begin
          ctl.look_step = 1'b1;
        end
      end
      S_HIT: begin
        if (sts.out_free) begin
          ctl.emit_hit = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (sts.use_hand) begin
          ctl.hand_pass = 1'b1;
        end else begin
          ctl.victim_take = 1'b1;
          state_next      = S_VREAD;
        end
      end
      S_VREAD: state_next = S_VEMIT;
      S_VEMIT: begin
        if (sts.out_free) begin
          ctl.emit_miss = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_FSCAN: begin
        if (sts.idx_dirty) begin
          state_next = S_FCAPT;
        end else if (sts.idx_end) begin
          state_next = S_FLAST;
        end else begin
          ctl.idx_step = 1'b1;
        end
      end
      S_FCAPT: begin
        if (sts.out_free || !sts.pend_valid) begin
          ctl.flush_capture = 1'b1;
          if (sts.cnt_full || sts.idx_end) begin
            state_next = S_FLAST;
          end else begin
            ctl.idx_step = 1'b1;
            state_next   = S_FSCAN;
          end
        end
      end
      S_FLAST: begin
        if (!sts.pend_valid) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          ctl.flush_finish = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  `CWBC_ASSERT_IMP(a_emit_needs_room, ctl.emit_hit || ctl.emit_miss || ctl.flush_finish, sts.out_free)
  `CWBC_ASSERT_IMP(a_single_emit, 1'b1, $onehot0({ctl.emit_hit, ctl.emit_miss, ctl.flush_finish, ctl.flush_capture}))
  `CWBC_ASSERT_NXT(a_accept_decodes, state == S_IDLE && in_valid, state == S_DECODE)

endmodule

// ===== design/cwbc_datapath.sv =====
// ---------------------------------------------------------------------------
// cwbc_datapath
// Tag memory, valid/dirty/use bits, clock hand, scan index and result register.
// ---------------------------------------------------------------------------
`include "clock_writeback_cache_controller_assert.svh"

module cwbc_datapath
  import cwbc_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          command,
  input  logic [SECTOR_W-1:0] sector,
  input  cwbc_ctl_t           ctl,
  output cwbc_sts_t           sts,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [SLOT_W-1:0]   slot,
  output logic                hit,
  output logic                writeback,
  output logic [SECTOR_W-1:0] writeback_sector,
  output logic                fill,
  output logic                last
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int XW = (IW > SLOT_W) ? IW : SLOT_W;
  localparam logic [IW-1:0] LastIdx = IW'(ENTRIES - 1);

  logic [SECTOR_W-1:0] tag_mem [ENTRIES];
  logic [SECTOR_W-1:0] rd_tag;
  logic [SECTOR_W-1:0] req_sector;
  logic [SECTOR_W-1:0] pend_tag;
  logic [1:0]          req_cmd;
  logic [ENTRIES-1:0]  valid_bits;
  logic [ENTRIES-1:0]  dirty_bits;
  logic [ENTRIES-1:0]  use_bits;
  logic [IW-1:0]       hand;
  logic [IW-1:0]       idx;
  logic [IW-1:0]       rd_idx;
  logic [IW-1:0]       pend_slot;
  logic [IW-1:0]       hand_inc;
  logic [IW-1:0]       idx_inc;
  logic                rd_ok;
  logic                pend_valid;
  logic [CNT_W-1:0]    cnt;
  logic                is_write;
  logic                victim_wb;
  logic                out_free;
  logic                pend_emit;

  // Slot numbers wider than the result field keep their low bits.
  function automatic logic [SLOT_W-1:0] to_slot(input logic [IW-1:0] i);
    logic [XW-1:0] e;
    e = XW'(i);
    return e[SLOT_W-1:0];
  endfunction

  assign hand_inc  = (hand == LastIdx) ? '0 : hand + 1'b1;
  assign idx_inc   = (idx == LastIdx) ? idx : idx + 1'b1;
  assign is_write  = (req_cmd == CMD_WRITE);
  assign victim_wb = valid_bits[idx] && dirty_bits[idx];
  assign out_free  = !out_valid || !out_stall;
  assign pend_emit = (ctl.flush_capture && pend_valid) || ctl.flush_finish;

  // Tag memory: one registered read at the scan index, one write.
  always_ff @(posedge clk) begin
    rd_tag <= tag_mem[idx];
    if (ctl.emit_miss) begin
      tag_mem[idx] <= req_sector;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      dirty_bits <= '0;
      use_bits   <= '0;
      hand       <= '0;
      idx        <= '0;
      rd_ok      <= 1'b0;
      pend_valid <= 1'b0;
      cnt        <= '0;
      out_valid  <= 1'b0;
    end else begin
      rd_ok <= ctl.look_step;
      if (ctl.look_start || ctl.flush_start) begin
        idx <= '0;
      end else if (ctl.look_step || ctl.idx_step) begin
        idx <= idx_inc;
      end else if (ctl.victim_take) begin
        idx <= hand;
      end
      if (ctl.hand_pass) begin
        use_bits[hand] <= 1'b0;
      end
      if (ctl.hand_pass || ctl.victim_take) begin
        hand <= hand_inc;
      end
      if (ctl.emit_hit) begin
        use_bits[rd_idx] <= 1'b1;
        if (is_write) begin
          dirty_bits[rd_idx] <= 1'b1;
        end
      end
      if (ctl.emit_miss) begin
        valid_bits[idx] <= 1'b1;
        dirty_bits[idx] <= is_write;
        use_bits[idx]   <= 1'b1;
      end
      if (ctl.flush_start) begin
        pend_valid <= 1'b0;
        cnt        <= '0;
      end
      if (ctl.flush_capture) begin
        dirty_bits[idx] <= 1'b0;
        pend_valid      <= 1'b1;
        cnt             <= cnt + 1'b1;
      end
      if (ctl.flush_finish) begin
        pend_valid <= 1'b0;
      end
      if (ctl.emit_hit || ctl.emit_miss || pend_emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.req_load) begin
      req_cmd    <= command;
      req_sector <= sector;
    end
    if (ctl.look_step) begin
      rd_idx <= idx;
    end
    if (ctl.flush_capture) begin
      pend_slot <= idx;
      pend_tag  <= rd_tag;
    end
    if (ctl.emit_hit) begin
      slot             <= to_slot(rd_idx);
      hit              <= 1'b1;
      writeback        <= 1'b0;
      writeback_sector <= '0;
      fill             <= 1'b0;
      last             <= 1'b1;
    end else if (ctl.emit_miss) begin
      slot             <= to_slot(idx);
      hit              <= 1'b0;
      writeback        <= victim_wb;
      writeback_sector <= victim_wb ? rd_tag : '0;
      fill             <= 1'b1;
      last             <= 1'b1;
    end else if (pend_emit) begin
      slot             <= to_slot(pend_slot);
      hit              <= 1'b0;
      writeback        <= 1'b1;
      writeback_sector <= pend_tag;
      fill             <= 1'b0;
      last             <= ctl.flush_finish;
    end
  end

  assign sts.req_cmd    = req_cmd;
  assign sts.match      = rd_ok && valid_bits[rd_idx] && (rd_tag == req_sector);
  assign sts.scan_end   = rd_ok && (rd_idx == LastIdx);
  assign sts.idx_end    = (idx == LastIdx);
  assign sts.use_hand   = use_bits[hand];
  assign sts.idx_dirty  = valid_bits[idx] && dirty_bits[idx];
  assign sts.cnt_full   = (cnt == CNT_W'(MAX_RESULTS - 1));
  assign sts.pend_valid = pend_valid;
  assign sts.out_free   = out_free;

  `CWBC_ASSERT_IMP(a_victim_unused, ctl.emit_miss, !use_bits[idx])
  `CWBC_ASSERT_IMP(a_hit_is_valid, ctl.emit_hit, valid_bits[rd_idx])
  `CWBC_ASSERT_IMP(a_flush_takes_dirty, ctl.flush_capture, valid_bits[idx] && dirty_bits[idx])

endmodule

// ===== design/clock_writeback_cache_controller.sv =====
// ---------------------------------------------------------------------------
// clock_writeback_cache_controller
// Tag and replacement controller of a fully associative write-back sector
// cache with clock (second-chance) replacement and flush-all.
// ---------------------------------------------------------------------------
//
//   Channel  Handshake            Payload
//   -------  -------------------  -------------------------------------------
//   input    in_valid / in_stall  command, sector
//   output   out_valid/out_stall  slot, hit, writeback, writeback_sector,
//                                 fill, last
//
// One request is handled at a time. A lookup walks the tag memory one entry
// a cycle through its registered read port. A miss adds the full walk, the
// clock sweep of one entry a cycle and the victim read (S_VREAD, then
// S_VEMIT). A flush walks the entries in order, passes through S_FCAPT for
// each dirty entry and ends early after MAX_RESULTS captures.
// Reset clears the valid, dirty and use bits and the hand at once; the tag
// memory itself is never cleared. A stalled result only holds the block
// when another result is due.
// ---------------------------------------------------------------------------
module clock_writeback_cache_controller
  import cwbc_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          command,
  input  logic [SECTOR_W-1:0] sector,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SLOT_W-1:0]   slot,
  output logic                hit,
  output logic                writeback,
  output logic [SECTOR_W-1:0] writeback_sector,
  output logic                fill,
  output logic                last
);

  // The controller sequences the walks; the datapath owns the cache and result state.
  cwbc_ctl_t ctl;
  cwbc_sts_t sts;

  cwbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  // Each result transfer leaves from a single output register, so a new
  // request is taken while the last result of the previous one still waits.
  cwbc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .command          (command),
    .sector           (sector),
    .ctl              (ctl),
    .sts              (sts),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .slot             (slot),
    .hit              (hit),
    .writeback        (writeback),
    .writeback_sector (writeback_sector),
    .fill             (fill),
    .last             (last)
  );

endmodule
